>>> src/vtb_pkg.sv
// shared types and constants for the virtual timer bank
package vtb_pkg;

  // bank geometry
  localparam int NUM_TIMERS   = 4;
  localparam int BANK_SIZE    = 4;
  localparam int TIMER_W      = 2;
  localparam int TICK_W       = 32;
  localparam int PERIOD_SHIFT = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_MASK  = 3'd4;

  // request commands
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [TIMER_W-1:0] timer_index;
    logic [TICK_W-1:0]  now_tick;
  } in_t;

  typedef struct packed {
    logic [TIMER_W-1:0] expired_index;
    logic               last;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic               load;
    logic               arm;
    logic               scan;
    logic               flush;
    logic [TIMER_W-1:0] scan_idx;
  } ctrl_t;

endpackage

>>> src/vtb_ctrl.sv
// controller state machine for the virtual timer bank
module vtb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cmd,
  output logic          busy,
  output vtb_pkg::ctrl_t ctrl
);
  import vtb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  localparam logic [TIMER_W-1:0] LAST_IDX = TIMER_W'(NUM_TIMERS - 1);

  state_t             state;
  logic [TIMER_W-1:0] scan_idx;
  logic               accept;

  assign accept = start && !busy;

  // state, scan counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      busy     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            busy  <= 1'b1;
            state <= (cmd == CMD_START) ? ST_ARM : ST_SCAN;
          end
        end
        ST_ARM: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= ST_FLUSH;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_FLUSH: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath commands
  always_comb begin
    ctrl.load     = accept;
    ctrl.arm      = (state == ST_ARM);
    ctrl.scan     = (state == ST_SCAN);
    ctrl.flush    = (state == ST_FLUSH);
    ctrl.scan_idx = scan_idx;
  end

endmodule

>>> src/vtb_dpath.sv
// timer state, config registers, compare and rearm datapath
module vtb_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  vtb_pkg::ctrl_t                 ctrl,
  input  vtb_pkg::in_t                   request,
  input  logic                           cfg_we,
  input  logic [vtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtb_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  output vtb_pkg::out_t                  result
);
  import vtb_pkg::*;

  logic [TICK_W-1:0]    period [BANK_SIZE];
  logic [BANK_SIZE-1:0] cyclic_mask;
  logic [TICK_W-1:0]    deadline [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] running;

  logic [TICK_W-1:0]  tick;
  logic [TIMER_W-1:0] arm_idx_q;
  logic               pend_valid;
  logic [TIMER_W-1:0] pend_idx;

  logic [TIMER_W-1:0] sel_idx;
  logic [TICK_W-1:0]  arm_sum;
  logic               hit;
  logic               arm_ok;

  // one shared adder: start arm or rearm during scan
  assign sel_idx = ctrl.arm ? arm_idx_q : ctrl.scan_idx;
  assign arm_sum = (period[sel_idx] >> PERIOD_SHIFT) + tick;
  assign arm_ok  = ({1'b0, arm_idx_q} < (TIMER_W + 1)'(NUM_TIMERS));

  // one timer compared per scan cycle
  assign hit = running[ctrl.scan_idx] && (tick > deadline[ctrl.scan_idx]);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANK_SIZE; i++) begin
        period[i] <= '0;
      end
      cyclic_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD_ZERO:  period[0] <= cfg_data;
        REG_PERIOD_ONE:   period[1] <= cfg_data;
        REG_PERIOD_TWO:   period[2] <= cfg_data;
        REG_PERIOD_THREE: period[3] <= cfg_data;
        REG_CYCLIC_MASK:  cyclic_mask <= cfg_data[BANK_SIZE-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tick      <= request.now_tick;
      arm_idx_q <= request.timer_index;
    end
  end

  // deadlines: payload only, gated by running
  always_ff @(posedge clk) begin
    if (ctrl.arm && arm_ok) begin
      deadline[arm_idx_q] <= arm_sum;
    end else if (ctrl.scan && hit && cyclic_mask[ctrl.scan_idx]) begin
      deadline[ctrl.scan_idx] <= arm_sum;
    end
  end

  // running flags and result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (ctrl.arm && arm_ok) begin
        running[arm_idx_q] <= 1'b1;
      end
      // an expiry waits one hit so the final one can be marked
      if (ctrl.scan && hit) begin
        running[ctrl.scan_idx] <= cyclic_mask[ctrl.scan_idx];
        if (pend_valid) begin
          result_valid <= 1'b1;
        end
        pend_valid <= 1'b1;
      end
      if (ctrl.flush) begin
        result_valid <= pend_valid;
        pend_valid   <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.scan && hit) begin
      pend_idx             <= ctrl.scan_idx;
      result.expired_index <= pend_idx;
      result.last          <= 1'b0;
    end else if (ctrl.flush) begin
      result.expired_index <= pend_idx;
      result.last          <= 1'b1;
    end
  end

endmodule

>>> src/virtual_timer_bank.sv
// top level of the virtual timer bank
//
//  channel   handshake            payload
//  request   start / busy         request (cmd, timer_index, now_tick)
//  result    result_valid strobe  result (expired_index, last)
//  config    cfg_we               cfg_index, cfg_data
//
// a start request keeps busy high for 1 cycle after it is taken
// a check request keeps busy high while each timer in turn goes through the
// shared compare and adder, then while the last result is marked
// results come out in the cycle after the next expiring timer is compared, the
// last one in the cycle busy falls; the receiver takes each result as it appears
// synchronous reset stops all timers and clears the periods and cyclic mask
module virtual_timer_bank (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  vtb_pkg::in_t                   request,
  output logic                           result_valid,
  output vtb_pkg::out_t                  result,
  input  logic                           cfg_we,
  input  logic [vtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vtb_pkg::*;

  ctrl_t ctrl;

  // controller
  vtb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (request.cmd),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // datapath
  vtb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> src/vtb_checker.sv
// port level checks for the virtual timer bank, bound to the top level
module vtb_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input vtb_pkg::in_t  request,
  input logic          result_valid,
  input vtb_pkg::out_t result
);
  import vtb_pkg::*;

  // a taken request always makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after a request");

  // a start request never produces a result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.cmd == CMD_START) |=> !result_valid)
    else $error("result after a start request");

  // the marked result closes the burst
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("result follows the last of a check");

  // an unmarked result means more of the check is still running
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("unmarked result while idle");

  // reset leaves the block idle
  assert property (@(posedge clk) rst |=> (!busy && !result_valid))
    else $error("not idle after reset");

endmodule

bind virtual_timer_bank vtb_checker u_vtb_checker (.*);
